>>> sv/bal_pkg.sv
// Shared constants for the bounded array list engine: operation and status codes and field widths.
package bal_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 4;
	localparam int ST_W   = 3;

	localparam logic [OP_W-1:0] OP_INS_POS  = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 4'd2;
	localparam logic [OP_W-1:0] OP_DEL_POS  = 4'd3;
	localparam logic [OP_W-1:0] OP_DEL_HEAD = 4'd4;
	localparam logic [OP_W-1:0] OP_DEL_TAIL = 4'd5;
	localparam logic [OP_W-1:0] OP_FIND     = 4'd6;
	localparam logic [OP_W-1:0] OP_REVERSE  = 4'd7;
	localparam logic [OP_W-1:0] OP_SORT_INS = 4'd8;
	localparam logic [OP_W-1:0] OP_READ     = 4'd9;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

>>> sv/bal_if.sv
// Valid/ready channel interfaces for the command and response words of the list engine.
interface bal_in_if #(parameter int IDX_W = 6) ();
	logic                                 valid;
	logic                                 ready;
	logic [bal_pkg::OP_W-1:0]             operation;
	logic [IDX_W-1:0]                     position;
	logic signed [bal_pkg::DATA_W-1:0]    value;

	modport source (output valid, output operation, output position, output value, input ready);
	modport sink (input valid, input operation, input position, input value, output ready);
endinterface

interface bal_out_if #(parameter int IDX_W = 6, parameter int CNT_W = 7) ();
	logic                                 valid;
	logic                                 ready;
	logic [bal_pkg::ST_W-1:0]             status;
	logic [IDX_W-1:0]                     found_index;
	logic signed [bal_pkg::DATA_W-1:0]    read_value;
	logic [CNT_W-1:0]                     count;

	modport source (output valid, output status, output found_index, output read_value,
		output count, input ready);
	modport sink (input valid, input status, input found_index, input read_value,
		input count, output ready);
endinterface

>>> sv/bal_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/bounded_array_list_engine.sv
// Top level of the bounded array list engine: sequencer around one shared entry RAM.
//
//  channel | dir | handshake     | word
//  cmd     | in  | valid / ready | operation, position, value
//  rsp     | out | valid / ready | status, found_index, read_value, count
//
// One command word is taken at a time; cmd.ready is high only while the sequencer is idle.
// Every memory move goes through the one RAM: inserts and deletes shift the entries behind the
// position one at a time, find and sorted insert scan from the head, and reverse swaps pairs
// from both ends; then the response register is loaded.
// The response register lets a new command be taken while the previous response still waits.
// Reset clears the count and control state; entry contents are never cleared.
module bounded_array_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bal_in_if.sink    cmd,
	bal_out_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DW    = bal_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_INS_END, S_PUT, S_DEL, S_DEL_END, S_FIND, S_FIND_END,
		S_SCAN, S_RV_RI, S_RV_RJ, S_RV_WI, S_RV_WJ, S_RD, S_RD_END, S_RESP
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         jdx_q;
	logic [IDX_W-1:0]         wa_q;
	logic [IDX_W-1:0]         pos_q;
	logic                     pend_q;
	logic                     hit_q;
	logic [DW-1:0]            val_q;
	logic [DW-1:0]            tmp_q;
	logic [bal_pkg::ST_W-1:0] res_st_q;
	logic [IDX_W-1:0]         res_fi_q;
	logic [DW-1:0]            res_rd_q;
	logic                     o_valid_q;
	logic [bal_pkg::ST_W-1:0] o_st_q;
	logic [IDX_W-1:0]         o_fi_q;
	logic [DW-1:0]            o_rd_q;
	logic [CNT_W-1:0]         o_cnt_q;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_wa;
	logic [DW-1:0]            ram_wd;
	logic                     ram_re;
	logic [IDX_W-1:0]         ram_ra;
	logic [DW-1:0]            ram_rd;

	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         pos_x;
	logic [IDX_W-1:0]         cnt_lo;
	logic [IDX_W-1:0]         ins_p;
	logic [CNT_W-1:0]         del_p;
	logic                     match;
	logic                     ge;

	state_t                   dec_state;
	logic [bal_pkg::ST_W-1:0] dec_st;
	logic [IDX_W-1:0]         dec_pos;
	logic [CNT_W-1:0]         dec_idx;
	logic [CNT_W-1:0]         dec_jdx;
	logic [CNT_W-1:0]         dec_cnt;

	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign pos_x  = CNT_W'(cmd.position);
	assign cnt_lo = cnt_q[IDX_W-1:0];
	assign match  = pend_q && (ram_rd == val_q);
	assign ge     = pend_q && ($signed(ram_rd) >= $signed(val_q));
	assign del_p  = (cmd.operation == bal_pkg::OP_DEL_HEAD) ? '0 : pos_x;

	always_comb begin
		unique case (cmd.operation)
			bal_pkg::OP_INS_HEAD: ins_p = '0;
			bal_pkg::OP_INS_TAIL: ins_p = cnt_lo;
			default:              ins_p = cmd.position;
		endcase
	end

	always_comb begin
		dec_state = S_RESP;
		dec_st    = bal_pkg::ST_OK;
		dec_pos   = cmd.position;
		dec_idx   = idx_q;
		dec_jdx   = jdx_q;
		dec_cnt   = cnt_q;
		unique case (cmd.operation)
			bal_pkg::OP_INS_POS, bal_pkg::OP_INS_HEAD,
			bal_pkg::OP_INS_TAIL: begin
				if (full) begin
					dec_st = bal_pkg::ST_FULL;
				end else if (pos_x > cnt_q &&
					cmd.operation == bal_pkg::OP_INS_POS) begin
					dec_st = bal_pkg::ST_BADPOS;
				end else begin
					dec_pos = ins_p;
					if (CNT_W'(ins_p) == cnt_q) begin
						dec_state = S_PUT;
					end else begin
						dec_idx   = cnt_q - CNT_W'(1);
						dec_state = S_INS;
					end
				end
			end
			bal_pkg::OP_DEL_POS, bal_pkg::OP_DEL_HEAD: begin
				if (empty) begin
					dec_st = bal_pkg::ST_EMPTY;
				end else if (del_p >= cnt_q) begin
					dec_st = bal_pkg::ST_BADPOS;
				end else if (del_p + CNT_W'(1) == cnt_q) begin
					dec_cnt = cnt_q - CNT_W'(1);
				end else begin
					dec_idx   = del_p + CNT_W'(1);
					dec_state = S_DEL;
				end
			end
			bal_pkg::OP_DEL_TAIL: begin
				if (empty) begin
					dec_st = bal_pkg::ST_EMPTY;
				end else begin
					dec_cnt = cnt_q - CNT_W'(1);
				end
			end
			bal_pkg::OP_FIND: begin
				if (empty) begin
					dec_st = bal_pkg::ST_EMPTY;
				end else begin
					dec_idx   = '0;
					dec_state = S_FIND;
				end
			end
			bal_pkg::OP_REVERSE: begin
				if (cnt_q > CNT_W'(1)) begin
					dec_idx   = '0;
					dec_jdx   = cnt_q - CNT_W'(1);
					dec_state = S_RV_RI;
				end
			end
			bal_pkg::OP_SORT_INS: begin
				if (full) begin
					dec_st = bal_pkg::ST_FULL;
				end else begin
					dec_idx   = '0;
					dec_state = S_SCAN;
				end
			end
			bal_pkg::OP_READ: begin
				if (pos_x >= cnt_q) begin
					dec_st = bal_pkg::ST_BADPOS;
				end else begin
					dec_state = S_RD;
				end
			end
			default: dec_state = S_RESP;
		endcase
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = o_valid_q;
	assign rsp.status      = o_st_q;
	assign rsp.found_index = o_fi_q;
	assign rsp.read_value  = o_rd_q;
	assign rsp.count       = o_cnt_q;

	always_comb begin
		ram_re = 1'b0;
		ram_ra = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_INS, S_DEL, S_FIND, S_RV_RI: ram_re = 1'b1;
			S_SCAN:                        ram_re = (idx_q < cnt_q);
			S_RV_RJ: begin
				ram_re = 1'b1;
				ram_ra = jdx_q[IDX_W-1:0];
			end
			S_RD: begin
				ram_re = 1'b1;
				ram_ra = pos_q;
			end
			default: ram_re = 1'b0;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = wa_q;
		ram_wd = ram_rd;
		unique case (state_q)
			S_INS, S_DEL:         ram_we = pend_q;
			S_INS_END, S_DEL_END: ram_we = 1'b1;
			S_PUT: begin
				ram_we = 1'b1;
				ram_wa = pos_q;
				ram_wd = val_q;
			end
			S_RV_WI: begin
				ram_we = 1'b1;
				ram_wa = idx_q[IDX_W-1:0];
			end
			S_RV_WJ: begin
				ram_we = 1'b1;
				ram_wa = jdx_q[IDX_W-1:0];
				ram_wd = tmp_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	bal_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			jdx_q     <= '0;
			wa_q      <= '0;
			pos_q     <= '0;
			pend_q    <= 1'b0;
			hit_q     <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_RESP) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						val_q    <= cmd.value;
						pos_q    <= dec_pos;
						res_st_q <= dec_st;
						res_fi_q <= '0;
						res_rd_q <= '0;
						pend_q   <= 1'b0;
						hit_q    <= 1'b0;
						idx_q    <= dec_idx;
						jdx_q    <= dec_jdx;
						cnt_q    <= dec_cnt;
						state_q  <= dec_state;
					end
				end
				S_INS: begin
					pend_q <= 1'b1;
					wa_q   <= IDX_W'(idx_q + CNT_W'(1));
					if (idx_q == CNT_W'(pos_q)) begin
						state_q <= S_INS_END;
					end else begin
						idx_q <= idx_q - CNT_W'(1);
					end
				end
				S_INS_END: begin
					pend_q  <= 1'b0;
					state_q <= S_PUT;
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_DEL: begin
					pend_q <= 1'b1;
					wa_q   <= IDX_W'(idx_q - CNT_W'(1));
					if (idx_q == cnt_q - CNT_W'(1)) begin
						state_q <= S_DEL_END;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_DEL_END: begin
					pend_q  <= 1'b0;
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_RESP;
				end
				S_FIND: begin
					if (match) begin
						hit_q    <= 1'b1;
						res_fi_q <= wa_q;
					end
					pend_q <= 1'b1;
					wa_q   <= idx_q[IDX_W-1:0];
					if (idx_q == cnt_q - CNT_W'(1)) begin
						state_q <= S_FIND_END;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_FIND_END: begin
					pend_q <= 1'b0;
					if (match) begin
						res_fi_q <= wa_q;
					end else if (!hit_q) begin
						res_st_q <= bal_pkg::ST_NOTFOUND;
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (ge) begin
						pos_q   <= wa_q;
						pend_q  <= 1'b0;
						idx_q   <= cnt_q - CNT_W'(1);
						state_q <= S_INS;
					end else if (idx_q == cnt_q) begin
						pos_q   <= cnt_lo;
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end else begin
						pend_q <= 1'b1;
						wa_q   <= idx_q[IDX_W-1:0];
						idx_q  <= idx_q + CNT_W'(1);
					end
				end
				S_RV_RI: state_q <= S_RV_RJ;
				S_RV_RJ: begin
					tmp_q   <= ram_rd;
					state_q <= S_RV_WI;
				end
				S_RV_WI: state_q <= S_RV_WJ;
				S_RV_WJ: begin
					idx_q <= idx_q + CNT_W'(1);
					jdx_q <= jdx_q - CNT_W'(1);
					if (idx_q + CNT_W'(2) < jdx_q) begin
						state_q <= S_RV_RI;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RD: state_q <= S_RD_END;
				S_RD_END: begin
					res_rd_q <= ram_rd;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (!o_valid_q || rsp.ready) begin
						o_valid_q <= 1'b1;
						o_st_q    <= res_st_q;
						o_fi_q    <= res_fi_q;
						o_rd_q    <= res_rd_q;
						o_cnt_q   <= cnt_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sv/bal_chk.sv
// Port-level assertions for the list engine and the bind that attaches them.
module bal_chk #(
	parameter int CAPACITY = 64,
	parameter int IDX_W    = 6,
	parameter int CNT_W    = 7
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [bal_pkg::ST_W-1:0] rsp_status,
	input logic [IDX_W-1:0]         rsp_found_index,
	input logic [bal_pkg::DATA_W-1:0] rsp_read_value,
	input logic [CNT_W-1:0]         rsp_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count)
		&& $stable(rsp_found_index) && $stable(rsp_read_value))
		else $error("Response word changed while stalled.");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_W'(CAPACITY))
		else $error("Count beyond capacity.");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bal_pkg::ST_FULL |-> rsp_count == CNT_W'(CAPACITY))
		else $error("Full reported with room left.");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bal_pkg::ST_EMPTY |-> rsp_count == '0)
		else $error("Empty reported with entries held.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != bal_pkg::ST_OK |-> rsp_found_index == '0
		&& rsp_read_value == '0)
		else $error("Failed operation returned data.");

endmodule

bind bounded_array_list_engine bal_chk #(
	.CAPACITY (CAPACITY),
	.IDX_W    (IDX_W),
	.CNT_W    (CNT_W)
) u_bal_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_index (rsp.found_index),
	.rsp_read_value  (rsp.read_value),
	.rsp_count       (rsp.count)
);

>>> bench/bal_list_checker.sv
`timescale 1ns / 100ps
// Checker for the list engine: mirrors the list on each command word and compares each response word.
module bal_list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	bal_in_if    cmd,
	bal_out_if   rsp,
	output int   failures,
	output int   outstanding
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int OP_W   = bal_pkg::OP_W;
	localparam int ST_W   = bal_pkg::ST_W;
	localparam int DATA_W = bal_pkg::DATA_W;
	localparam int CMP_W  = DATA_W + 1;

	typedef logic signed [CMP_W-1:0] field_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic [IDX_W-1:0]         found_index;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
	} list_reply_t;

	logic signed [DATA_W-1:0] list_mem [CAPACITY];
	int                       entry_total = 0;
	list_reply_t              reply_queue [$];
	list_reply_t              awaited;
	int                       fail_count = 0;

	assign failures = fail_count;

	function automatic list_reply_t apply_list_op(input logic [OP_W-1:0] op,
		input logic [IDX_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_reply_t              r;
		int                       at;
		int                       lo;
		int                       hi;
		logic signed [DATA_W-1:0] swap;
		logic                     hit;
		r = '0;
		unique case (op)
		bal_pkg::OP_INS_POS, bal_pkg::OP_INS_HEAD, bal_pkg::OP_INS_TAIL,
		bal_pkg::OP_SORT_INS: begin
			at = 0;
			if (op == bal_pkg::OP_INS_POS)
				at = int'(pos);
			else if (op == bal_pkg::OP_INS_TAIL)
				at = entry_total;
			else if (op == bal_pkg::OP_SORT_INS) begin
				while (at < entry_total && list_mem[at] < val)
					at++;
			end
			if (entry_total >= CAPACITY)
				r.status = bal_pkg::ST_FULL;
			else if (at > entry_total)
				r.status = bal_pkg::ST_BADPOS;
			else begin
				for (int i = entry_total; i > at; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[at] = val;
				entry_total++;
			end
		end
		bal_pkg::OP_DEL_POS, bal_pkg::OP_DEL_HEAD, bal_pkg::OP_DEL_TAIL: begin
			at = 0;
			if (op == bal_pkg::OP_DEL_POS)
				at = int'(pos);
			else if (op == bal_pkg::OP_DEL_TAIL)
				at = entry_total - 1;
			if (entry_total == 0)
				r.status = bal_pkg::ST_EMPTY;
			else if (at >= entry_total)
				r.status = bal_pkg::ST_BADPOS;
			else begin
				for (int i = at; i + 1 < entry_total; i++)
					list_mem[i] = list_mem[i + 1];
				entry_total--;
			end
		end
		bal_pkg::OP_FIND: begin
			hit = 1'b0;
			for (int i = 0; i < entry_total; i++) begin
				if (list_mem[i] == val) begin
					hit = 1'b1;
					r.found_index = IDX_W'(i);
				end
			end
			if (entry_total == 0)
				r.status = bal_pkg::ST_EMPTY;
			else if (!hit)
				r.status = bal_pkg::ST_NOTFOUND;
		end
		bal_pkg::OP_REVERSE: begin
			lo = 0;
			hi = entry_total - 1;
			while (lo < hi) begin
				swap = list_mem[lo];
				list_mem[lo] = list_mem[hi];
				list_mem[hi] = swap;
				lo++;
				hi--;
			end
		end
		bal_pkg::OP_READ: begin
			if (int'(pos) >= entry_total)
				r.status = bal_pkg::ST_BADPOS;
			else
				r.read_value = list_mem[pos];
		end
		default: begin
		end
		endcase
		r.count = CNT_W'(entry_total);
		return r;
	endfunction

	task automatic check_field(input string name, input field_t want, input field_t got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (reply_queue.size() == 0) begin
					$error("Response word arrived with no command outstanding.");
					fail_count++;
				end else begin
					awaited = reply_queue.pop_front();
					check_field("status", field_t'(awaited.status), field_t'(rsp.status));
					check_field("found_index", field_t'(awaited.found_index),
						field_t'(rsp.found_index));
					check_field("read_value", field_t'(awaited.read_value),
						field_t'(rsp.read_value));
					check_field("count", field_t'(awaited.count), field_t'(rsp.count));
				end
			end
			if (cmd.valid && cmd.ready)
				reply_queue.push_back(apply_list_op(cmd.operation, cmd.position, cmd.value));
			outstanding = reply_queue.size();
		end
	end

endmodule

>>> bench/bounded_array_list_engine_test.sv
`timescale 1ns / 100ps
// Top of the list engine testbench: clock, reset, command stimulus, response back-pressure and verdict.
module bounded_array_list_engine_test;

	localparam int CAPACITY    = 64;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int OP_W        = bal_pkg::OP_W;
	localparam int DATA_W      = bal_pkg::DATA_W;
	localparam int ITEM_TOTAL  = 1750;
	localparam int PHASE_LEN   = 120;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 150;

	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = bal_pkg::OP_READ + 1'b1;
	localparam logic [OP_W-1:0] OP_LAST_CODE    = '1;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	logic clk;
	logic arst_n;
	logic steady;
	int   fail_count;
	int   outstanding;
	int   quiet_cycles = 0;

	logic [OP_W-1:0]          insert_ops [4];
	logic [OP_W-1:0]          delete_ops [3];
	logic [OP_W-1:0]          other_ops [3];
	logic signed [DATA_W-1:0] value_pool [8];

	bal_in_if #(.IDX_W(IDX_W)) cmd ();
	bal_out_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp ();

	bounded_array_list_engine #(.CAPACITY(CAPACITY)) DUT (
		.clk,
		.arst_n,
		.cmd(cmd),
		.rsp(rsp)
	);

	bal_list_checker #(.CAPACITY(CAPACITY)) list_check (
		.clk,
		.arst_n,
		.cmd(cmd),
		.rsp(rsp),
		.failures(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		rsp.ready <= arst_n && (steady || $urandom_range(99) >= 28);

	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] pos,
		input logic signed [DATA_W-1:0] val);
		while (!steady && $urandom_range(99) < 28) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.position <= pos;
		cmd.value <= val;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	initial begin
		int                       mode;
		int                       roll;
		int                       ins_share;
		int                       del_share;
		logic [OP_W-1:0]          op;
		logic [IDX_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		insert_ops = '{bal_pkg::OP_INS_POS, bal_pkg::OP_INS_HEAD, bal_pkg::OP_INS_TAIL,
			bal_pkg::OP_SORT_INS};
		delete_ops = '{bal_pkg::OP_DEL_POS, bal_pkg::OP_DEL_HEAD, bal_pkg::OP_DEL_TAIL};
		other_ops = '{bal_pkg::OP_FIND, bal_pkg::OP_REVERSE, bal_pkg::OP_READ};
		arst_n = 1'b0;
		steady <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.operation <= bal_pkg::OP_INS_POS;
		cmd.position <= '0;
		cmd.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases on an empty list first, then a short list holding the extreme values.
		send_word(bal_pkg::OP_FIND, '0, 5);
		send_word(bal_pkg::OP_DEL_POS, '0, 0);
		send_word(bal_pkg::OP_DEL_HEAD, '0, 0);
		send_word(bal_pkg::OP_DEL_TAIL, '0, 0);
		send_word(bal_pkg::OP_READ, '0, 0);
		send_word(bal_pkg::OP_REVERSE, '0, 0);
		send_word(OP_LAST_CODE, '1, -1);
		send_word(OP_FIRST_UNUSED, '0, 0);
		send_word(bal_pkg::OP_INS_POS, IDX_W'(1), 7);
		send_word(bal_pkg::OP_INS_POS, '0, VAL_MIN);
		send_word(bal_pkg::OP_REVERSE, '0, 0);
		send_word(bal_pkg::OP_INS_HEAD, '0, VAL_MAX);
		send_word(bal_pkg::OP_INS_TAIL, '0, -1);
		send_word(bal_pkg::OP_INS_POS, IDX_W'(3), 0);
		send_word(bal_pkg::OP_DEL_POS, IDX_W'(4), 0);
		send_word(bal_pkg::OP_REVERSE, '0, 0);
		send_word(bal_pkg::OP_SORT_INS, '0, VAL_MAX);
		send_word(bal_pkg::OP_SORT_INS, '0, VAL_MIN);
		send_word(bal_pkg::OP_FIND, '0, VAL_MAX);
		send_word(bal_pkg::OP_FIND, '0, 12345);
		send_word(bal_pkg::OP_READ, '0, 0);
		send_word(bal_pkg::OP_READ, '1, 0);
		send_word(bal_pkg::OP_READ, IDX_W'(5), 0);
		send_word(bal_pkg::OP_DEL_POS, IDX_W'(1), 0);
		send_word(bal_pkg::OP_DEL_HEAD, '0, 0);

		mode = 0;
		for (int n = 0; n < ITEM_TOTAL; n++) begin
			if (n % PHASE_LEN == 0) begin
				mode = (n / PHASE_LEN) % 4;
				foreach (value_pool[k])
					value_pool[k] = $urandom;
				value_pool[0] = VAL_MIN;
				value_pool[1] = VAL_MAX;
				value_pool[2] = 0;
				value_pool[3] = -1;
			end
			steady <= (n >= 700 && n < 1000);
			ins_share = (mode == 0) ? 70 : (mode == 2) ? 8 : 35;
			del_share = (mode == 0) ? 8 : (mode == 2) ? 70 : 30;
			roll = $urandom_range(99);
			if (roll < 2)
				op = OP_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
			else if (roll < 2 + ins_share)
				op = insert_ops[$urandom_range(3)];
			else if (roll < 2 + ins_share + del_share)
				op = delete_ops[$urandom_range(2)];
			else
				op = other_ops[$urandom_range(2)];
			pos = $urandom_range(1) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
			val = ($urandom_range(99) < 45) ? value_pool[$urandom_range(7)] : $urandom;
			send_word(op, pos, val);
		end
		cmd.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
